@@ hw/rtl/tli_pkg.sv @@
// Package: shared types and constants of the table linear interpolator.
`timescale 1ns / 1ps
`default_nettype none
package tli_pkg;
   localparam int TableDepthDefault = 64;
   localparam int MaterialsDefault  = 2;
   localparam int CmdDepth          = 2;

   localparam logic [1:0] REQ_WRITE_BP    = 2'd0;
   localparam logic [1:0] REQ_WRITE_VALUE = 2'd1;
   localparam logic [1:0] REQ_QUERY       = 2'd2;
   localparam logic [1:0] REQ_UNUSED      = 2'd3;

   localparam logic [1:0] CSR_TABLE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_WARN_LOW     = 2'd1;
   localparam logic [1:0] CSR_WARN_HIGH    = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_WINDOW  = 2'd1;
   localparam logic [1:0] STATUS_BAD_MAT = 2'd2;

   localparam logic [6:0]  TableLengthReset = 7'd48;
   localparam logic [23:0] WarnLowReset     = 24'd16000;
   localparam logic [23:0] WarnHighReset    = 24'd1552000;

   // One classified query handed from front to back.
   typedef struct packed {
      logic [1:0]  material;
      logic [23:0] energy;
      logic        bad_mat;
      logic [1:0]  status;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SEARCH,
      ST_LOAD,
      ST_DIVIDE,
      ST_VALUES,
      ST_MULT,
      ST_EMIT
   } state_type;
endpackage
`default_nettype wire

@@ hw/rtl/tli_front.sv @@
// Front: accepts beats, writes tables, classifies queries into a command queue.
`timescale 1ns / 1ps
`default_nettype none
module tli_front #(
   parameter int TABLE_DEPTH = tli_pkg::TableDepthDefault,
   parameter int MATERIALS   = tli_pkg::MaterialsDefault,
   localparam int IW = $clog2(TABLE_DEPTH),
   localparam int VW = $clog2(TABLE_DEPTH * MATERIALS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [1:0]        req_type,
   input  wire logic [1:0]        req_material,
   input  wire logic [5:0]        req_entry_index,
   input  wire logic [31:0]       req_load_word,
   input  wire logic [23:0]       req_energy,
   input  wire logic [23:0]       warn_low,
   input  wire logic [23:0]       warn_high,
   output logic                   bp_we,
   output logic [IW-1:0]          bp_waddr,
   output logic [23:0]            bp_wdata,
   output logic                   val_we,
   output logic [VW-1:0]          val_waddr,
   output logic [31:0]            val_wdata,
   output logic                   cmd_valid,
   output tli_pkg::cmd_type       cmd_data,
   input  wire logic              cmd_take,
   input  wire logic              back_busy
);
   localparam int QW = $clog2(tli_pkg::CmdDepth);
   tli_pkg::cmd_type q_ff [tli_pkg::CmdDepth];
   logic [QW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QW:0]   cnt_ff, cnt_in;
   logic          acc, idx_ok, mat_ok, enq, is_load;
   tli_pkg::cmd_type new_cmd;

   // table writes wait until no query is queued or in the back end
   assign is_load = (req_type == tli_pkg::REQ_WRITE_BP) ||
                    (req_type == tli_pkg::REQ_WRITE_VALUE);
   assign full   = (cnt_ff == (QW+1)'(tli_pkg::CmdDepth)) ||
                   (is_load && (cnt_ff != '0 || back_busy));
   assign acc    = push && !full;
   assign idx_ok = ({26'd0, req_entry_index} < TABLE_DEPTH);
   assign mat_ok = (req_material >= 2'd1) && ({30'd0, req_material} <= MATERIALS);

   assign bp_we     = acc && req_type == tli_pkg::REQ_WRITE_BP && idx_ok;
   assign bp_waddr  = IW'(req_entry_index);
   assign bp_wdata  = req_load_word[23:0];
   assign val_we    = acc && req_type == tli_pkg::REQ_WRITE_VALUE && idx_ok && mat_ok;
   assign val_waddr = VW'((32'(req_material) - 32'd1) * TABLE_DEPTH + 32'(req_entry_index));
   assign val_wdata = req_load_word;

   assign enq = acc && req_type == tli_pkg::REQ_QUERY;
   always_comb begin
      new_cmd.material = req_material;
      new_cmd.energy   = req_energy;
      new_cmd.bad_mat  = !mat_ok;
      if (!mat_ok) new_cmd.status = tli_pkg::STATUS_BAD_MAT;
      else if (req_energy < warn_low || req_energy > warn_high)
         new_cmd.status = tli_pkg::STATUS_WINDOW;
      else new_cmd.status = tli_pkg::STATUS_OK;
   end

   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ff];
   always_comb begin
      wr_in  = enq ? QW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = cmd_take ? QW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (QW+1)'(enq) - (QW+1)'(cmd_take);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (enq) q_ff[wr_ff] <= new_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !enq) else $error("command queue overflow");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("take from empty command queue");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QW+1)'(tli_pkg::CmdDepth)) else $error("queue count out of range");
endmodule
`default_nettype wire

@@ hw/rtl/tli_back.sv @@
// Back: table memories, breakpoint search, serial divider, multiply, result register.
`timescale 1ns / 1ps
`default_nettype none
module tli_back #(
   parameter int TABLE_DEPTH = tli_pkg::TableDepthDefault,
   parameter int MATERIALS   = tli_pkg::MaterialsDefault,
   localparam int IW = $clog2(TABLE_DEPTH),
   localparam int VW = $clog2(TABLE_DEPTH * MATERIALS),
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              bp_we,
   input  wire logic [IW-1:0]     bp_waddr,
   input  wire logic [23:0]       bp_wdata,
   input  wire logic              val_we,
   input  wire logic [VW-1:0]     val_waddr,
   input  wire logic [31:0]       val_wdata,
   input  wire logic [6:0]        table_length,
   input  wire logic              cmd_valid,
   input  tli_pkg::cmd_type       cmd_data,
   output logic                   cmd_take,
   output logic                   busy,
   output logic                   empty,
   input  wire logic              pop,
   output logic [31:0]            rsp_atten_length,
   output logic [1:0]             rsp_status
);
   logic [23:0] bp_mem [TABLE_DEPTH];
   logic [31:0] val_mem [TABLE_DEPTH * MATERIALS];
   logic [23:0] bp_rd_ff;
   logic [31:0] val_rd_ff;
   logic [IW-1:0] bp_ra;
   logic [VW-1:0] va;

   tli_pkg::state_type st_ff, st_in;
   tli_pkg::cmd_type cmd_ff;
   logic [IW-1:0] hi_ff, hi_in, lo_ff, lo_in, last;
   logic [CW-1:0] n_used;
   logic [23:0]   blo_ff, blo_in, span_ff, span_in;
   logic [39:0]   rem_ff, rem_in;
   logic [15:0]   frac_ff, frac_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [31:0]   vlo_ff, vlo_in;
   logic [1:0]    vstep_ff, vstep_in;
   logic [47:0]   prod_ff, prod_in;
   logic          neg_ff, neg_in;
   logic [31:0]   dif;
   logic          out_v_ff, out_v_in;
   logic [31:0]   out_d_ff, out_d_in;
   logic [1:0]    out_s_ff, out_s_in;
   logic [40:0]   trial;
   logic [VW-1:0] base;

   always_comb begin
      if ({25'd0, table_length} < 32'd2) n_used = CW'(2);
      else if ({25'd0, table_length} > TABLE_DEPTH) n_used = CW'(TABLE_DEPTH);
      else n_used = CW'(table_length);
   end
   assign last = IW'(n_used - CW'(1));
   assign base = VW'((32'(cmd_ff.material) - 32'd1) * TABLE_DEPTH);

   // Read addresses set by state; the read data is registered and arrives in the next cycle.
   always_comb begin
      bp_ra = hi_in;
      va    = VW'(base + VW'(hi_ff));
      unique case (st_ff)
         tli_pkg::ST_FIRST:  bp_ra = '0;
         tli_pkg::ST_LAST:   bp_ra = last;
         tli_pkg::ST_VALUES: va = (vstep_ff == 2'd0) ? VW'(base + VW'(lo_ff))
                                                      : VW'(base + VW'(hi_ff));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bp_we) bp_mem[bp_waddr] <= bp_wdata;
      if (val_we) val_mem[val_waddr] <= val_wdata;
      bp_rd_ff  <= bp_mem[bp_ra];
      val_rd_ff <= val_mem[va];
   end

   assign dif   = neg_ff ? (vlo_ff - val_rd_ff) : (val_rd_ff - vlo_ff);
   assign trial = {rem_ff, 1'b0} - {17'd0, span_ff};
   assign cmd_take = (st_ff == tli_pkg::ST_IDLE) && cmd_valid;
   assign busy = (st_ff != tli_pkg::ST_IDLE);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         tli_pkg::ST_IDLE:   if (cmd_valid)
                                st_in = cmd_data.bad_mat ? tli_pkg::ST_EMIT : tli_pkg::ST_FIRST;
         tli_pkg::ST_FIRST:  st_in = tli_pkg::ST_LAST;
         tli_pkg::ST_LAST:   st_in = (cmd_ff.energy < bp_rd_ff) ? tli_pkg::ST_VALUES
                                     : tli_pkg::ST_SEARCH;
         tli_pkg::ST_SEARCH: st_in = (cmd_ff.energy >= bp_rd_ff) ? tli_pkg::ST_VALUES
                                     : tli_pkg::ST_LOAD;
         tli_pkg::ST_LOAD:   if (cmd_ff.energy < bp_rd_ff || hi_ff == last)
                                st_in = tli_pkg::ST_DIVIDE;
         tli_pkg::ST_DIVIDE: if (cnt_ff == 5'd0) st_in = tli_pkg::ST_VALUES;
         tli_pkg::ST_VALUES: if (vstep_ff == 2'd2) st_in = tli_pkg::ST_MULT;
         tli_pkg::ST_MULT:   st_in = tli_pkg::ST_EMIT;
         tli_pkg::ST_EMIT:   if (!out_v_ff || pop) st_in = tli_pkg::ST_IDLE;
         default:            st_in = tli_pkg::ST_IDLE;
      endcase
   end

   // Datapath: search, division one quotient bit per cycle, value reads, then multiply.
   always_comb begin
      hi_in = hi_ff; lo_in = lo_ff; blo_in = blo_ff; span_in = span_ff; rem_in = rem_ff;
      frac_in = frac_ff; cnt_in = cnt_ff; vlo_in = vlo_ff;
      vstep_in = vstep_ff; prod_in = prod_ff; neg_in = neg_ff;
      unique case (st_ff)
         tli_pkg::ST_IDLE: begin
            vstep_in = '0;
         end
         tli_pkg::ST_FIRST: ;
         tli_pkg::ST_LAST: begin
            // bp_rd_ff holds bp[0] here; below it the first value is returned
            blo_in = bp_rd_ff;
            hi_in  = '0;
            lo_in  = '0;
            frac_in = '0;
         end
         tli_pkg::ST_SEARCH: begin
            // bp_rd_ff holds bp[last]; at or above it the last value is returned
            if (cmd_ff.energy >= bp_rd_ff) begin
               hi_in = last;
               lo_in = last;
               frac_in = '0;
            end else hi_in = IW'(1);
         end
         tli_pkg::ST_LOAD: begin
            if (cmd_ff.energy < bp_rd_ff || hi_ff == last) begin
               lo_in   = IW'(hi_ff - 1'b1);
               span_in = bp_rd_ff - blo_ff;
               rem_in  = '0;
               rem_in[39:16] = '0;
               frac_in = '0;
               cnt_in  = 5'd16;
               // dividend = (e - blo) << 16; rem starts at e - blo and zeros shift in below
               rem_in = {16'd0, cmd_ff.energy - blo_ff};
            end else begin
               blo_in = bp_rd_ff;
               hi_in  = IW'(hi_ff + 1'b1);
            end
         end
         tli_pkg::ST_DIVIDE: begin
            if (cnt_ff != 5'd0) begin
               if (!trial[40]) begin
                  rem_in = trial[39:0]; frac_in = {frac_ff[14:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[38:0], 1'b0}; frac_in = {frac_ff[14:0], 1'b0};
               end
               cnt_in = cnt_ff - 5'd1;
            end
         end
         tli_pkg::ST_VALUES: begin
            vstep_in = vstep_ff + 2'd1;
            if (vstep_ff == 2'd1) vlo_in = val_rd_ff;
         end
         tli_pkg::ST_MULT: begin
            neg_in  = 1'b0;
            prod_in = {16'd0, dif} * {32'd0, frac_ff};
         end
         tli_pkg::ST_EMIT: ;
         default: ;
      endcase
      if (st_ff == tli_pkg::ST_VALUES && vstep_ff == 2'd2) begin
         neg_in = val_rd_ff < vlo_ff;
      end
   end

   // The quotient division above covers e-blo < span, so bits fit in 40 bits.
   always_comb begin
      out_v_in = out_v_ff; out_d_in = out_d_ff; out_s_in = out_s_ff;
      if (pop && out_v_ff) out_v_in = 1'b0;
      if (st_ff == tli_pkg::ST_EMIT && (!out_v_ff || pop)) begin
         out_v_in = 1'b1;
         out_s_in = cmd_ff.status;
         if (cmd_ff.bad_mat) out_d_in = '0;
         else if (neg_ff) out_d_in = vlo_ff - prod_ff[47:16];
         else out_d_in = vlo_ff + prod_ff[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= tli_pkg::ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_v_ff <= out_v_in;
      end
      if (cmd_take) cmd_ff <= cmd_data;
      hi_ff <= hi_in; lo_ff <= lo_in; blo_ff <= blo_in; span_ff <= span_in;
      rem_ff <= rem_in; frac_ff <= frac_in; cnt_ff <= cnt_in; vlo_ff <= vlo_in;
      vstep_ff <= vstep_in; prod_ff <= prod_in;
      neg_ff <= (st_ff == tli_pkg::ST_MULT) ? neg_ff : neg_in;
      out_d_ff <= out_d_in; out_s_ff <= out_s_in;
   end

   assign empty = !out_v_ff;
   assign rsp_atten_length = out_d_ff;
   assign rsp_status = out_s_ff;

   a_frac_div: assert property (@(posedge clock) disable iff (reset)
      (st_ff == tli_pkg::ST_DIVIDE && cnt_ff != 5'd0) |=> cnt_ff == $past(cnt_ff) - 5'd1)
      else $error("divider count slipped");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff == tli_pkg::ST_EMIT && out_v_ff && !pop) |=> st_ff == tli_pkg::ST_EMIT)
      else $error("result overwritten");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> st_ff != tli_pkg::ST_IDLE) else $error("command dropped");
endmodule
`default_nettype wire

@@ hw/rtl/tli_csr.sv @@
// Configuration registers: table length and warning window.
`timescale 1ns / 1ps
`default_nettype none
module tli_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output logic [6:0]       table_length,
   output logic [23:0]      warn_low,
   output logic [23:0]      warn_high
);
   logic [6:0]  len_ff;
   logic [23:0] lo_ff, hi_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= tli_pkg::TableLengthReset;
         lo_ff  <= tli_pkg::WarnLowReset;
         hi_ff  <= tli_pkg::WarnHighReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            tli_pkg::CSR_TABLE_LENGTH: len_ff <= csr_data[6:0];
            tli_pkg::CSR_WARN_LOW:     lo_ff  <= csr_data[23:0];
            tli_pkg::CSR_WARN_HIGH:    hi_ff  <= csr_data[23:0];
            default: ;
         endcase
      end
   end
   assign table_length = len_ff;
   assign warn_low = lo_ff;
   assign warn_high = hi_ff;
endmodule
`default_nettype wire

@@ hw/rtl/table_linear_interpolator_unit.sv @@
// Top level of the table linear interpolator.
// Load beats write the breakpoint and value tables when they are accepted;
// they are held off while a query is queued or in the back end. A query walks
// the breakpoints one per cycle from the second, then runs a 16-bit restoring
// divider, reads the two bracketing values and does one multiply. Energies
// below the first or at or above the last breakpoint skip the walk and the
// divider, and an invalid material goes straight to the result register. A
// two-entry command queue lets query beats be taken while the back end works,
// and the result register frees the back end.
`timescale 1ns / 1ps
`default_nettype none
module table_linear_interpolator_unit #(
   parameter int TABLE_DEPTH = tli_pkg::TableDepthDefault,
   parameter int MATERIALS   = tli_pkg::MaterialsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_type,
   input  wire logic [1:0]  req_material,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic [31:0] req_load_word,
   input  wire logic [23:0] req_energy,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_atten_length,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int VW = $clog2(TABLE_DEPTH * MATERIALS);
   logic [6:0] table_length;
   logic [23:0] warn_low, warn_high, bp_wdata;
   logic bp_we, val_we, cmd_valid, cmd_take, back_busy;
   logic [IW-1:0] bp_waddr;
   logic [VW-1:0] val_waddr;
   logic [31:0] val_wdata;
   tli_pkg::cmd_type cmd_data;

   tli_csr u_csr (.clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .table_length, .warn_low, .warn_high);

   tli_front #(.TABLE_DEPTH(TABLE_DEPTH), .MATERIALS(MATERIALS)) u_front (
      .clock, .reset, .push, .full, .req_type, .req_material, .req_entry_index,
      .req_load_word, .req_energy, .warn_low, .warn_high, .bp_we, .bp_waddr,
      .bp_wdata, .val_we, .val_waddr, .val_wdata, .cmd_valid, .cmd_data, .cmd_take,
      .back_busy);

   tli_back #(.TABLE_DEPTH(TABLE_DEPTH), .MATERIALS(MATERIALS)) u_back (
      .clock, .reset, .bp_we, .bp_waddr, .bp_wdata, .val_we, .val_waddr, .val_wdata,
      .table_length, .cmd_valid, .cmd_data, .cmd_take, .busy(back_busy), .empty, .pop,
      .rsp_atten_length, .rsp_status);
endmodule
`default_nettype wire
